FILE: design/double_ended_queue_with_insert_assert.svh
// Assertion macros for the deque block.
// Used by deq_ctrl; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_WITH_INSERT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_INSERT_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/deq_pkg.sv
// Shared constants, types and ring-index helper for the deque block.
// No dependencies.
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 3'd0,
    CMD_PUSH_TAIL = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_READ_AT   = 3'd3,
    CMD_POP_HEAD  = 3'd4,
    CMD_POP_TAIL  = 3'd5,
    CMD_CLEAR     = 3'd6
  } deq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } deq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CAPTURE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR
  } deq_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    deq_status_t              status;
  } deq_result_t;

  // physical slot of logical position pos, pos < DEPTH + 1
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(pos);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

FILE: design/deq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/deq_ctrl.sv
// Command sequencer: ring pointers, end-value cache and RAM read-modify-write.
// Depends on deq_pkg and double_ended_queue_with_insert_assert.svh.
`include "double_ended_queue_with_insert_assert.svh"

module deq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [deq_pkg::CMD_W-1:0]   command,
  input  logic [deq_pkg::CNT_W-1:0]   index,
  input  logic [deq_pkg::DATA_W-1:0]  value,
  output logic                        wr_en,
  output logic [deq_pkg::ADDR_W-1:0]  wr_addr,
  output logic [deq_pkg::DATA_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [deq_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [deq_pkg::DATA_W-1:0]  rd_data,
  input  logic                        out_free,
  output logic                        load,
  output deq_pkg::deq_result_t        res
);
  import deq_pkg::*;

  deq_state_t        state, state_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [DATA_W-1:0] front_q, front_next;
  logic [DATA_W-1:0] back_q, back_next;
  deq_cmd_t          cmd_q;
  logic [CNT_W-1:0]  idx_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] res_read;
  deq_status_t       res_status;
  logic              req_accept;
  logic              empty, full;
  logic [ADDR_W-1:0] head_dec, head_inc;

  assign req_accept = req_valid && !req_stall;
  assign empty      = (cnt == '0);
  assign full       = (cnt == CNT_W'(DEPTH));
  assign head_dec   = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc   = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    front_q <= front_next;
    back_q  <= back_next;
    if (req_accept) begin
      cmd_q <= deq_cmd_t'(command);
      idx_q <= index;
      val_q <= value;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    k_next     = k;
    front_next = front_q;
    back_next  = back_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = val_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    res_read   = '0;
    res_status = STAT_OK;
    req_stall  = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUSH_HEAD: begin
            load = 1'b1;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = head_dec;
              head_next  = head_dec;
              cnt_next   = cnt + 1'b1;
              front_next = val_q;
              if (empty) begin
                back_next = val_q;
              end
            end
          end
          CMD_PUSH_TAIL: begin
            load = 1'b1;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = slot_of(head, cnt);
              cnt_next  = cnt + 1'b1;
              back_next = val_q;
              if (empty) begin
                front_next = val_q;
              end
            end
          end
          CMD_INSERT: begin
            if (idx_q > cnt) begin
              load       = 1'b1;
              res_status = STAT_RANGE;
            end else if (full) begin
              load       = 1'b1;
              res_status = STAT_FULL;
            end else if (idx_q == cnt) begin
              load      = 1'b1;
              wr_en     = 1'b1;
              wr_addr   = slot_of(head, cnt);
              cnt_next  = cnt + 1'b1;
              back_next = val_q;
              if (empty) begin
                front_next = val_q;
              end
            end else begin
              k_next     = cnt;
              state_next = S_SHIFT_RD;
            end
          end
          CMD_READ_AT: begin
            if (empty) begin
              load       = 1'b1;
              res_read   = '1;
              res_status = STAT_EMPTY;
            end else if (idx_q >= cnt) begin
              load       = 1'b1;
              res_read   = '1;
              res_status = STAT_RANGE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = slot_of(head, idx_q);
              state_next = S_CAPTURE;
            end
          end
          CMD_POP_HEAD: begin
            if (empty) begin
              load       = 1'b1;
              res_status = STAT_EMPTY;
            end else if (cnt == CNT_W'(1)) begin
              load      = 1'b1;
              cnt_next  = '0;
              head_next = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = slot_of(head, CNT_W'(1));
              head_next  = head_inc;
              cnt_next   = cnt - 1'b1;
              state_next = S_CAPTURE;
            end
          end
          CMD_POP_TAIL: begin
            if (empty) begin
              load       = 1'b1;
              res_status = STAT_EMPTY;
            end else if (cnt == CNT_W'(1)) begin
              load      = 1'b1;
              cnt_next  = '0;
              head_next = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = slot_of(head, cnt - CNT_W'(2));
              cnt_next   = cnt - 1'b1;
              state_next = S_CAPTURE;
            end
          end
          CMD_CLEAR: begin
            load      = 1'b1;
            cnt_next  = '0;
            head_next = '0;
          end
          default: begin
            load = 1'b1;
          end
        endcase
      end
      S_CAPTURE: begin
        load = 1'b1;
        unique case (cmd_q)
          CMD_READ_AT:  res_read   = rd_data;
          CMD_POP_HEAD: front_next = rd_data;
          CMD_POP_TAIL: back_next  = rd_data;
          default: ;
        endcase
      end
      S_SHIFT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = slot_of(head, k - CNT_W'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head, k);
        wr_data = rd_data;
        k_next  = k - CNT_W'(1);
        if ((k - CNT_W'(1)) == idx_q) begin
          state_next = S_INS_WR;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_INS_WR: begin
        load     = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = slot_of(head, idx_q);
        cnt_next = cnt + 1'b1;
        if (idx_q == '0) begin
          front_next = val_q;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      state_next = S_IDLE;
      // result slot busy: hold everything and retry
      if (!out_free) begin
        state_next = state;
        head_next  = head;
        cnt_next   = cnt;
        front_next = front_q;
        back_next  = back_q;
        wr_en      = 1'b0;
        load       = 1'b0;
      end
    end

    res.read_value  = res_read;
    res.front_value = (cnt_next == '0) ? '1 : front_next;
    res.back_value  = (cnt_next == '0) ? '1 : back_next;
    res.count       = cnt_next;
    res.is_empty    = (cnt_next == '0);
    res.status      = res_status;
  end

  `DEQ_ASSERT_IMPLY(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH))
  `DEQ_ASSERT_IMPLY(a_empty_head, clk, rst, cnt == '0, head == '0)
  `DEQ_ASSERT_IMPLY(a_load_free, clk, rst, load, out_free)
  `DEQ_ASSERT_IMPLY(a_shift_range, clk, rst, state == S_SHIFT_RD, k > idx_q)
  `DEQ_ASSERT_NEXT(a_accept_exec, clk, rst, req_accept, state == S_EXEC)

endmodule

FILE: design/deq_obuf.sv
// Result register between the sequencer and the response channel.
// Depends on deq_pkg.
module deq_obuf (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  deq_pkg::deq_result_t               res,
  output logic                               out_free,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [deq_pkg::DATA_W-1:0]  read_value,
  output logic signed [deq_pkg::DATA_W-1:0]  front_value,
  output logic signed [deq_pkg::DATA_W-1:0]  back_value,
  output logic [deq_pkg::CNT_W-1:0]          count,
  output logic                               is_empty,
  output logic [deq_pkg::STAT_W-1:0]         status
);
  import deq_pkg::*;

  deq_result_t res_q;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign read_value  = res_q.read_value;
  assign front_value = res_q.front_value;
  assign back_value  = res_q.back_value;
  assign count       = res_q.count;
  assign is_empty    = res_q.is_empty;
  assign status      = res_q.status;

endmodule

FILE: design/double_ended_queue_with_insert.sv
// Bounded deque of signed words in a ring buffer of DEPTH entries held in one
// single-port-read RAM. Commands: push front/back, insert before a position,
// read at a position, pop front/back, clear; each returns one result with the
// read value, front, back, count, empty flag and status. Pushes, clear, errors,
// insert at the back end and single-element pops finish in the execute state;
// read_at and pops that leave elements add one RAM read and a capture state;
// insert at position i below the count c shifts each of the c-i displaced
// entries up by a RAM read then a RAM write before the new word is written.
// A stalled result channel holds the transaction until the result register is free.
// No clearing pass after reset; storage is only read where it was written.
// Depends on deq_pkg, deq_ram, deq_ctrl and deq_obuf.
module double_ended_queue_with_insert (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [deq_pkg::CMD_W-1:0]          command,
  input  logic [deq_pkg::CNT_W-1:0]          index,
  input  logic signed [deq_pkg::DATA_W-1:0]  value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [deq_pkg::DATA_W-1:0]  read_value,
  output logic signed [deq_pkg::DATA_W-1:0]  front_value,
  output logic signed [deq_pkg::DATA_W-1:0]  back_value,
  output logic [deq_pkg::CNT_W-1:0]          count,
  output logic                               is_empty,
  output logic [deq_pkg::STAT_W-1:0]         status
);
  import deq_pkg::*;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              out_free;
  logic              load;
  deq_result_t       res;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .command   (command),
    .index     (index),
    .value     (value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .load      (load),
    .res       (res)
  );

  deq_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .res         (res),
    .out_free    (out_free),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_value  (read_value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for double_ended_queue_with_insert: directed and random
// command streams with a transaction-level predictor and random idling on both channels.
// Depends on deq_pkg and the double_ended_queue_with_insert RTL.
module tb;
  import deq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_ERR = '1;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_TXNS = 620;
  localparam int PRINT_LIMIT = 30;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [CMD_W-1:0]         command = '0;
  logic [CNT_W-1:0]         index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic [STAT_W-1:0]        status;

  double_ended_queue_with_insert u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .index       (index),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_value  (read_value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // predictor state
  logic signed [DATA_W-1:0] deque_words [DEPTH];
  int deque_head = 0;
  int deque_count = 0;

  deq_result_t expected_results[$];
  int error_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_range = 0;
  int n_empty = 0;
  int peak_count = 0;
  bit no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int deque_slot(input int pos);
    return (deque_head + pos) % DEPTH;
  endfunction

  function automatic deq_result_t predict_result(input logic [CMD_W-1:0] cmd,
                                                 input logic [CNT_W-1:0] idx,
                                                 input logic signed [DATA_W-1:0] val);
    deq_result_t r;
    int k;
    r = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH_HEAD: begin
        if (deque_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_words[deque_head] = val;
          deque_count++;
        end
      end
      CMD_PUSH_TAIL: begin
        if (deque_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          deque_words[deque_slot(deque_count)] = val;
          deque_count++;
        end
      end
      CMD_INSERT: begin
        if (int'(idx) > deque_count) begin
          r.status = STAT_RANGE;
        end else if (deque_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (k = deque_count; k > int'(idx); k--) begin
            deque_words[deque_slot(k)] = deque_words[deque_slot(k - 1)];
          end
          deque_words[deque_slot(int'(idx))] = val;
          deque_count++;
        end
      end
      CMD_READ_AT: begin
        if (deque_count == 0) begin
          r.read_value = WORD_ERR;
          r.status = STAT_EMPTY;
        end else if (int'(idx) >= deque_count) begin
          r.read_value = WORD_ERR;
          r.status = STAT_RANGE;
        end else begin
          r.read_value = deque_words[deque_slot(int'(idx))];
        end
      end
      CMD_POP_HEAD, CMD_POP_TAIL: begin
        if (deque_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (cmd == CMD_POP_HEAD) begin
            deque_head = (deque_head + 1) % DEPTH;
          end
          deque_count--;
          if (deque_count == 0) begin
            deque_head = 0;
          end
        end
      end
      CMD_CLEAR: begin
        deque_count = 0;
        deque_head = 0;
      end
      default: begin
      end
    endcase
    if (deque_count == 0) begin
      r.front_value = WORD_ERR;
      r.back_value = WORD_ERR;
    end else begin
      r.front_value = deque_words[deque_slot(0)];
      r.back_value = deque_words[deque_slot(deque_count - 1)];
    end
    r.count = CNT_W'(deque_count);
    r.is_empty = (deque_count == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ERR;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("tb: error: %s", msg);
    end
  endtask

  // called right after a rising edge; leaves valid high for a back-to-back transaction
  task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] idx,
                          input logic signed [DATA_W-1:0] val);
    int gap;
    deq_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    index <= idx;
    value <= val;
    do begin
      @(posedge clk);
    end while (req_stall);
    r = predict_result(cmd, idx, val);
    expected_results = {expected_results, r};
    n_sent++;
    case (r.status)
      STAT_FULL:  n_full++;
      STAT_RANGE: n_range++;
      STAT_EMPTY: n_empty++;
      default: begin
      end
    endcase
    if (deque_count > peak_count) begin
      peak_count = deque_count;
    end
  endtask

  task automatic send_random_op(input bit grow);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = CNT_W'($urandom_range(0, DEPTH));
    if (r < (grow ? 50 : 20)) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
    end else if (r < (grow ? 65 : 30)) begin
      cmd = CMD_INSERT;
      if ($urandom_range(0, 9) != 0) begin
        idx = CNT_W'($urandom_range(0, deque_count));
      end
    end else if (r < (grow ? 85 : 55)) begin
      cmd = CMD_READ_AT;
      if (deque_count > 0 && $urandom_range(0, 9) != 0) begin
        idx = CNT_W'($urandom_range(0, deque_count - 1));
      end
    end else if (r < 96) begin
      cmd = $urandom_range(0, 1) ? CMD_POP_TAIL : CMD_POP_HEAD;
    end else if (r < 98) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_UNDEFINED;
    end
    send_txn(cmd, idx, pick_word());
  endtask

  task automatic test_empty_deque();
    send_txn(CMD_POP_HEAD, '0, '0);
    send_txn(CMD_POP_TAIL, '0, '0);
    send_txn(CMD_READ_AT, '0, '0);
    send_txn(CMD_READ_AT, CNT_W'(DEPTH), '0);
    send_txn(CMD_INSERT, CNT_W'(1), WORD_MAX);
    send_txn(CMD_CLEAR, '0, '0);
    send_txn(CMD_UNDEFINED, CNT_W'(DEPTH), WORD_MIN);
  endtask

  task automatic test_end_and_insert_ops();
    send_txn(CMD_INSERT, '0, WORD_MIN);
    send_txn(CMD_PUSH_TAIL, '0, WORD_MAX);
    send_txn(CMD_PUSH_HEAD, '0, '0);
    send_txn(CMD_INSERT, CNT_W'(3), WORD_ERR);
    send_txn(CMD_INSERT, CNT_W'(1), $urandom);
    send_txn(CMD_READ_AT, '0, '0);
    send_txn(CMD_READ_AT, CNT_W'(4), '0);
    send_txn(CMD_READ_AT, CNT_W'(5), '0);
    send_txn(CMD_READ_AT, CNT_W'(DEPTH), '0);
    send_txn(CMD_INSERT, CNT_W'(DEPTH), $urandom);
    send_txn(CMD_POP_HEAD, '0, '0);
    send_txn(CMD_POP_TAIL, '0, '0);
    send_txn(CMD_CLEAR, '0, '0);
  endtask

  task automatic test_full_deque();
    logic [CMD_W-1:0] cmd;
    while (deque_count < DEPTH) begin
      no_idle = (deque_count >= DEPTH / 2);
      case ($urandom_range(0, 2))
        0: cmd = CMD_PUSH_HEAD;
        1: cmd = CMD_PUSH_TAIL;
        default: cmd = CMD_INSERT;
      endcase
      send_txn(cmd, CNT_W'($urandom_range(0, deque_count)), pick_word());
    end
    no_idle = 1'b0;
    send_txn(CMD_PUSH_HEAD, '0, $urandom);
    send_txn(CMD_PUSH_TAIL, '0, $urandom);
    send_txn(CMD_INSERT, CNT_W'(DEPTH), $urandom);
    send_txn(CMD_INSERT, '0, $urandom);
    send_txn(CMD_READ_AT, CNT_W'(DEPTH - 1), '0);
    send_txn(CMD_READ_AT, CNT_W'(DEPTH), '0);
    send_txn(CMD_UNDEFINED, '0, $urandom);
    while (deque_count > 0) begin
      send_txn($urandom_range(0, 1) ? CMD_POP_TAIL : CMD_POP_HEAD, '0, '0);
    end
  endtask

  task automatic test_random_ops();
    int i;
    bit grow;
    grow = 1'b1;
    for (i = 0; i < RANDOM_TXNS; i++) begin
      if (i % 60 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (deque_count >= DEPTH - 1 && $urandom_range(0, 3) == 0) begin
        grow = 1'b0;
      end else if (deque_count <= 1 && $urandom_range(0, 3) == 0) begin
        grow = 1'b1;
      end
      send_random_op(grow);
    end
    no_idle = 1'b0;
  endtask

  initial begin : rsp_stall_gen
    int n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    deq_result_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report_error("result with no transaction outstanding");
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (read_value !== exp_r.read_value) begin
          report_error($sformatf("result %0d read_value %0h, want %0h",
                                 n_checked, read_value, exp_r.read_value));
        end
        if (front_value !== exp_r.front_value) begin
          report_error($sformatf("result %0d front_value %0h, want %0h",
                                 n_checked, front_value, exp_r.front_value));
        end
        if (back_value !== exp_r.back_value) begin
          report_error($sformatf("result %0d back_value %0h, want %0h",
                                 n_checked, back_value, exp_r.back_value));
        end
        if (count !== exp_r.count) begin
          report_error($sformatf("result %0d count %0d, want %0d",
                                 n_checked, count, exp_r.count));
        end
        if (is_empty !== exp_r.is_empty) begin
          report_error($sformatf("result %0d is_empty %0b, want %0b",
                                 n_checked, is_empty, exp_r.is_empty));
        end
        if (status !== exp_r.status) begin
          report_error($sformatf("result %0d status %0d, want %0d",
                                 n_checked, status, exp_r.status));
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout, %0d results outstanding", expected_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : main
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_deque();
    test_end_and_insert_ops();
    test_full_deque();
    test_random_ops();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked, peak occupancy %0d",
             n_sent, n_checked, peak_count);
    $display("tb: refusals when full %0d, range errors %0d, empty errors %0d",
             n_full, n_range, n_empty);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
